// ===== sv/bkh_pkg.sv =====
// ----------------------------------------------------------------------------
// bkh_pkg
// Types, constants and mixing functions shared by the byte key hash block.
// ----------------------------------------------------------------------------
`default_nettype none

package bkh_pkg;

  localparam logic [31:0] GOLDEN    = 32'h9e3779b9;
  localparam int          BLOCK_LEN = 12;
  localparam int          QDEPTH    = 4;
  localparam int          QPTR_W    = $clog2(QDEPTH);
  localparam logic [3:0]  MIX_LAST  = 4'd8;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } mix_t;

  // One unit of work for the mixer: an optional full block and/or a key finish.
  typedef struct packed {
    logic                     init;
    logic [31:0]              seed;
    logic                     blk;
    logic                     fin;
    logic [8*BLOCK_LEN-1:0]   bytes;
    logic [3:0]               cnt;
    logic [31:0]              len;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIX,
    ST_TAIL,
    ST_HOLD
  } back_state_t;

  // One line of the nine-line mix.
  function automatic mix_t mix_step(mix_t w, logic [3:0] step);
    mix_t       r;
    logic [4:0] sh;
    r  = w;
    sh = 5'd0;
    unique case (step)
      4'd0: sh = 5'd13;
      4'd1: sh = 5'd8;
      4'd2: sh = 5'd13;
      4'd3: sh = 5'd12;
      4'd4: sh = 5'd16;
      4'd5: sh = 5'd5;
      4'd6: sh = 5'd3;
      4'd7: sh = 5'd10;
      4'd8: sh = 5'd15;
      default: sh = 5'd0;
    endcase
    unique case (step)
      4'd0, 4'd3, 4'd6: r.a = (w.a - w.b - w.c) ^ (w.c >> sh);
      4'd1, 4'd4, 4'd7: r.b = (w.b - w.c - w.a) ^ (w.a << sh);
      4'd2, 4'd5, 4'd8: r.c = (w.c - w.a - w.b) ^ (w.b >> sh);
      default: r = w;
    endcase
    return r;
  endfunction

  // Tail bytes below cnt; the low byte of c stays free.
  function automatic mix_t tail_words(logic [8*BLOCK_LEN-1:0] bytes, logic [3:0] cnt);
    mix_t                   r;
    logic [8*BLOCK_LEN-1:0] m;
    for (int i = 0; i < BLOCK_LEN; i++) begin
      m[8*i +: 8] = (4'(i) < cnt) ? bytes[8*i +: 8] : 8'h00;
    end
    r.a = m[31:0];
    r.b = m[63:32];
    r.c = {m[87:64], 8'h00};
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/bkh_front.sv =====
// ----------------------------------------------------------------------------
// bkh_front
// Takes key bytes, builds 12-byte blocks and issues mix jobs to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bkh_front import bkh_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // key_byte[7:0], seed[39:8]
  input  wire logic [1:0]  s_tuser,   // byte_present[0], first[1]
  input  wire logic        s_tlast,
  input  wire logic        q_full,
  output logic             q_push,
  output job_t             q_job
);

  logic [8*BLOCK_LEN-1:0] blk_bytes;
  logic [3:0]             pos;
  logic [31:0]            len;
  logic                   pend_init;
  logic [31:0]            pend_seed;

  logic [7:0]             key_byte;
  logic [31:0]            seed;
  logic                   present;
  logic                   first;
  logic                   xfer;
  logic [3:0]             pos0;
  logic [31:0]            len0;
  logic [3:0]             pos_new;
  logic [31:0]            len_new;
  logic                   full_blk;
  logic                   need_job;
  logic [8*BLOCK_LEN-1:0] bytes_new;

  assign key_byte = s_tdata[7:0];
  assign seed     = s_tdata[39:8];
  assign present  = s_tuser[0];
  assign first    = s_tuser[1];

  assign s_tready = !q_full;
  assign xfer     = s_tvalid && s_tready;

  always_comb begin
    pos0    = first ? 4'd0 : pos;
    len0    = first ? 32'd0 : len;
    bytes_new = blk_bytes;
    for (int i = 0; i < BLOCK_LEN; i++) begin
      if (present && (4'(i) == pos0)) begin
        bytes_new[8*i +: 8] = key_byte;
      end
    end
    pos_new  = pos0 + {3'd0, present};
    len_new  = len0 + {31'd0, present};
    full_blk = (pos_new == 4'(BLOCK_LEN));
    need_job = full_blk || s_tlast;

    q_job.init  = pend_init || first;
    q_job.seed  = first ? seed : pend_seed;
    q_job.blk   = full_blk;
    q_job.fin   = s_tlast;
    q_job.bytes = bytes_new;
    q_job.cnt   = full_blk ? 4'd0 : pos_new;
    q_job.len   = len_new;
  end

  assign q_push = xfer && need_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= 4'd0;
      len       <= 32'd0;
      pend_init <= 1'b1;
      pend_seed <= 32'd0;
    end else if (xfer) begin
      if (s_tlast) begin
        pos       <= 4'd0;
        len       <= 32'd0;
        pend_init <= 1'b1;
        pend_seed <= 32'd0;
      end else begin
        pos <= full_blk ? 4'd0 : pos_new;
        len <= len_new;
        if (need_job) begin
          pend_init <= 1'b0;
        end else if (first) begin
          pend_init <= 1'b1;
          pend_seed <= seed;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      blk_bytes <= bytes_new;
    end
  end

endmodule

`default_nettype wire

// ===== sv/bkh_queue.sv =====
// ----------------------------------------------------------------------------
// bkh_queue
// Small job queue between the byte front and the mixer.
// ----------------------------------------------------------------------------
`default_nettype none

module bkh_queue import bkh_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  job_t      wr_job,
  output logic      full,
  input  wire logic pop,
  output job_t      rd_job,
  output logic      empty
);

  job_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full   = (count == (QPTR_W + 1)'(QDEPTH));
  assign empty  = (count == '0);
  assign rd_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (QPTR_W + 1)'(1);
        2'b01:   count <= count - (QPTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

endmodule

`default_nettype wire

// ===== sv/bkh_back.sv =====
// ----------------------------------------------------------------------------
// bkh_back
// Mixer: adds block or tail words into a, b, c, runs the mix one line per
// cycle and presents the hash in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bkh_back import bkh_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_empty,
  input  job_t             q_job,
  output logic             q_pop,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata    // hash[31:0]
);

  back_state_t state;
  back_state_t state_next;
  logic [3:0]  step;
  logic [3:0]  step_next;
  mix_t        words;
  mix_t        words_next;
  logic        tail_pend;
  logic        tail_pend_next;
  logic        fin;
  logic        fin_next;
  logic [31:0] len;
  logic [31:0] len_next;
  logic        hash_valid;
  logic        out_load;
  logic [31:0] hash;

  mix_t        base;
  mix_t        tail;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= 4'd0;
      tail_pend <= 1'b0;
      fin       <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      tail_pend <= tail_pend_next;
      fin       <= fin_next;
    end
  end

  always_ff @(posedge clk) begin
    words <= words_next;
    len   <= len_next;
  end

  always_comb begin
    state_next     = state;
    step_next      = step;
    words_next     = words;
    tail_pend_next = tail_pend;
    fin_next       = fin;
    len_next       = len;
    q_pop          = 1'b0;
    out_load       = 1'b0;
    base.a = q_job.init ? GOLDEN : words.a;
    base.b = q_job.init ? GOLDEN : words.b;
    base.c = q_job.init ? q_job.seed : words.c;
    tail   = tail_words(q_job.bytes, q_job.cnt);
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          fin_next  = q_job.fin;
          len_next  = q_job.len;
          step_next = 4'd0;
          if (q_job.blk) begin
            words_next.a   = base.a + q_job.bytes[31:0];
            words_next.b   = base.b + q_job.bytes[63:32];
            words_next.c   = base.c + q_job.bytes[95:64];
            tail_pend_next = q_job.fin;
          end else begin
            words_next.a   = base.a + tail.a;
            words_next.b   = base.b + tail.b;
            words_next.c   = base.c + tail.c + q_job.len;
            tail_pend_next = 1'b0;
          end
          state_next = ST_MIX;
        end
      end
      ST_MIX: begin
        words_next = mix_step(words, step);
        if (step == MIX_LAST) begin
          step_next = 4'd0;
          if (tail_pend) begin
            state_next = ST_TAIL;
          end else if (fin) begin
            state_next = ST_HOLD;
          end else begin
            state_next = ST_IDLE;
          end
        end else begin
          step_next = step + 4'd1;
        end
      end
      ST_TAIL: begin
        // block ended the key: no tail bytes, only the length
        words_next.c   = words.c + len;
        tail_pend_next = 1'b0;
        step_next      = 4'd0;
        state_next     = ST_MIX;
      end
      ST_HOLD: begin
        if (!hash_valid || m_tready) begin
          out_load   = 1'b1;
          fin_next   = 1'b0;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_valid <= 1'b0;
    end else if (out_load) begin
      hash_valid <= 1'b1;
    end else if (m_tready) begin
      hash_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      hash <= words.c;
    end
  end

  assign m_tvalid = hash_valid;
  assign m_tdata  = hash;

  a_mix_step_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_MIX |-> step <= MIX_LAST)
    else $error("mix step out of range");

  a_pop_when_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == ST_IDLE) && !q_empty)
    else $error("queue popped outside idle or while empty");

  a_tail_then_mix: assert property (@(posedge clk) disable iff (rst)
    state == ST_TAIL |=> (state == ST_MIX) && (step == 4'd0))
    else $error("tail add not followed by a fresh mix");

  a_load_only_final: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (state == ST_HOLD) && fin)
    else $error("hash loaded outside a finished key");

endmodule

`default_nettype wire

// ===== sv/byte_key_hash_32.sv =====
// ----------------------------------------------------------------------------
// byte_key_hash_32
// Streaming 32-bit key hash (lookup2 scheme), one key byte per transfer.
//
//   channel  dir  signals                      contents
//   s_*      in   tvalid tready tdata tuser    key_byte, seed; byte_present, first;
//                 tlast                        last
//   m_*      out  tvalid tready tdata          hash
//
// Bytes are taken at one per cycle while the job queue (4 entries) has room.
// The mixer adds each full block and runs the nine mix lines; a key finish adds the
// tail words and length (after a block that ended the key, the length alone), runs
// the mix and loads the hash into the output register. Reset is synchronous, with
// no clearing pass.
// A stalled output holds the finished hash while the front keeps taking bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_key_hash_32 import bkh_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // key_byte[7:0], seed[39:8]
  input  wire logic [1:0]  s_tuser,   // byte_present[0], first[1]
  input  wire logic        s_tlast,   // last
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata    // hash[31:0]
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  job_t wr_job;
  job_t rd_job;

  bkh_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (wr_job)
  );

  bkh_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_job (wr_job),
    .full   (q_full),
    .pop    (q_pop),
    .rd_job (rd_job),
    .empty  (q_empty)
  );

  bkh_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_job    (rd_job),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire
